@@ rtl/hrba_pkg.sv @@
// Package for the handle region bump allocator: sizes, command, status and
// micro-operation codes, and the control/status structs. No dependencies.
`default_nettype none
package hrba_pkg;

    localparam int HANDLE_COUNT = 32;
    localparam int LUMP_BYTES   = 16384;
    localparam int LUMP_COUNT   = 64;
    localparam int HEADER_BYTES = 16;

    localparam int HANDLE_W = 5;
    localparam int LUMP_W   = $clog2(LUMP_COUNT);
    localparam int LINK_W   = LUMP_W + 1;
    localparam int FILL_W   = 15;
    localparam int ADDR_W   = 20;
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 3;
    localparam int COUNT_W  = LINK_W;

    localparam logic [LINK_W-1:0] NO_LINK     = LINK_W'(LUMP_COUNT);
    localparam logic [FILL_W-1:0] USABLE      = FILL_W'(LUMP_BYTES - HEADER_BYTES);
    localparam logic [FILL_W-1:0] HEADER_FILL = FILL_W'(HEADER_BYTES);

    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MARK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FROM   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK            = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_HANDLE     = 3'd1;
    localparam logic [STAT_W-1:0] ST_POOL_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_HANDLE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE      = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_IN_REGION = 3'd5;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_CREATE    = 4'd1;
    localparam logic [OP_W-1:0] OP_LOAD_CUR  = 4'd2;
    localparam logic [OP_W-1:0] OP_ALLOC_NEW = 4'd3;
    localparam logic [OP_W-1:0] OP_BUMP      = 4'd4;
    localparam logic [OP_W-1:0] OP_MARK      = 4'd5;
    localparam logic [OP_W-1:0] OP_STEP      = 4'd6;
    localparam logic [OP_W-1:0] OP_LAST      = 4'd7;
    localparam logic [OP_W-1:0] OP_LAST_FREE = 4'd8;
    localparam logic [OP_W-1:0] OP_SEARCH    = 4'd9;
    localparam logic [OP_W-1:0] OP_MATCH     = 4'd10;

    typedef struct packed {
        logic              idle;
        logic [OP_W-1:0]   op;
        logic              finish;
        logic [STAT_W-1:0] status;
    } t_ctl;

    typedef struct packed {
        logic             accept;
        logic [CMD_W-1:0] cmd;
        logic             hfree_any;
        logic             lfree_any;
        logic             handle_ok;
        logic             size_ok;
        logic             need_lump;
        logic             match;
        logic             link_end;
        logic             out_free;
    } t_sts;

    function automatic logic [ADDR_W-1:0] lump_addr(input logic [LUMP_W-1:0] lump,
                                                    input logic [FILL_W-1:0] off);
        return ADDR_W'(lump) * ADDR_W'(LUMP_BYTES) + ADDR_W'(off);
    endfunction

endpackage
`default_nettype wire

@@ rtl/hrba_if.sv @@
// Channel interfaces of the allocator: the command word in, the result word out.
// Depends on hrba_pkg.
`default_nettype none
interface hrba_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [hrba_pkg::CMD_W-1:0]    command;
    logic [hrba_pkg::HANDLE_W-1:0] handle_in;
    logic [hrba_pkg::FILL_W-1:0]   byte_count;
    logic [hrba_pkg::ADDR_W-1:0]   rollback_address;
    modport source (output valid, command, handle_in, byte_count, rollback_address,
                    input ready);
    modport sink   (input valid, command, handle_in, byte_count, rollback_address,
                    output ready);
endinterface

interface hrba_res_if;
    logic                          valid;
    logic                          ready;
    logic [hrba_pkg::STAT_W-1:0]   status;
    logic [hrba_pkg::HANDLE_W-1:0] handle_out;
    logic [hrba_pkg::ADDR_W-1:0]   address_out;
    modport source (output valid, status, handle_out, address_out, input ready);
    modport sink   (input valid, status, handle_out, address_out, output ready);
endinterface
`default_nettype wire

@@ rtl/hrba_ctrl.sv @@
// Controller of the allocator: sequences each command word through decode,
// head read and chain walks. Depends on hrba_pkg.
`default_nettype none
module hrba_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire hrba_pkg::t_sts i_sts,
    output hrba_pkg::t_ctl   o_ctl
);
    import hrba_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_HEAD   = 3'd2;
    localparam logic [2:0] S_LUMP   = 3'd3;
    localparam logic [2:0] S_ROLL   = 3'd4;

    localparam logic [COUNT_W-1:0] LAST_STEP = COUNT_W'(LUMP_COUNT - 1);

    logic [2:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_newer, n_newer;
    t_ctl               c;

    always_comb begin
        c        = '0;
        c.idle   = (r_state == S_IDLE);
        c.op     = OP_NONE;
        c.status = ST_OK;
        n_state  = r_state;
        n_count  = r_count;
        n_newer  = r_newer;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_sts.cmd == CMD_CREATE) begin
                    c.finish = 1'b1;
                    if (!i_sts.hfree_any) begin
                        c.status = ST_NO_HANDLE;
                    end else if (!i_sts.lfree_any) begin
                        c.status = ST_POOL_EMPTY;
                    end else begin
                        c.op = OP_CREATE;
                    end
                end else if (i_sts.cmd == CMD_ALLOC && !i_sts.size_ok) begin
                    c.finish = 1'b1;
                    c.status = ST_BAD_SIZE;
                end else if ((i_sts.cmd == CMD_ALLOC || i_sts.cmd == CMD_FREE ||
                              i_sts.cmd == CMD_MARK || i_sts.cmd == CMD_FROM) &&
                             i_sts.handle_ok) begin
                    n_state = S_HEAD;
                end else begin
                    c.finish = 1'b1;
                    c.status = ST_BAD_HANDLE;
                end
            end
            S_HEAD: begin
                c.op    = OP_LOAD_CUR;
                n_count = '0;
                n_state = S_LUMP;
            end
            S_LUMP: begin
                unique case (i_sts.cmd)
                    CMD_ALLOC: begin
                        c.finish = 1'b1;
                        if (!i_sts.need_lump) begin
                            c.op = OP_BUMP;
                        end else if (i_sts.lfree_any) begin
                            c.op = OP_ALLOC_NEW;
                        end else begin
                            c.status = ST_POOL_EMPTY;
                        end
                    end
                    CMD_MARK: begin
                        c.op     = OP_MARK;
                        c.finish = 1'b1;
                    end
                    CMD_FREE: begin
                        if (i_sts.link_end || r_count == LAST_STEP) begin
                            c.op     = OP_LAST_FREE;
                            c.finish = 1'b1;
                        end else begin
                            c.op    = OP_STEP;
                            n_count = r_count + 1'b1;
                        end
                    end
                    default: begin
                        // Rollback search, newest lump first.
                        if (i_sts.match) begin
                            c.op    = OP_MATCH;
                            n_newer = r_count;
                            n_count = '0;
                            if (r_count == '0) begin
                                c.finish = 1'b1;
                            end else begin
                                n_state = S_ROLL;
                            end
                        end else if (i_sts.link_end || r_count == LAST_STEP) begin
                            c.finish = 1'b1;
                            c.status = ST_NOT_IN_REGION;
                        end else begin
                            c.op    = OP_SEARCH;
                            n_count = r_count + 1'b1;
                        end
                    end
                endcase
            end
            S_ROLL: begin
                if (i_sts.link_end || r_count + 1'b1 == r_newer) begin
                    c.op     = OP_LAST;
                    c.finish = 1'b1;
                end else begin
                    c.op    = OP_STEP;
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // A result cannot be loaded while the previous one still waits.
        if (c.finish && !i_sts.out_free) begin
            c.finish = 1'b0;
            c.op     = OP_NONE;
            c.status = ST_OK;
            n_state  = r_state;
            n_count  = r_count;
            n_newer  = r_newer;
        end else if (c.finish) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_newer <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_newer <= n_newer;
        end
    end

    assign o_ctl = c;

endmodule
`default_nettype wire

@@ rtl/hrba_dp.sv @@
// Datapath of the allocator: input and output registers, handle and lump
// busy bits, head, link and fill memories. Depends on hrba_pkg and hrba_if.
`default_nettype none
module hrba_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    hrba_cmd_if.sink            i_cmd,
    hrba_res_if.source          o_res,
    input  wire hrba_pkg::t_ctl i_ctl,
    output hrba_pkg::t_sts      o_sts
);
    import hrba_pkg::*;

    logic [CMD_W-1:0]    r_cmd;
    logic [HANDLE_W-1:0] r_h;
    logic [FILL_W-1:0]   r_bytes;
    logic [ADDR_W-1:0]   r_where;

    logic [HANDLE_COUNT-1:0] r_in_use;
    logic [LUMP_COUNT-1:0]   r_busy;

    logic [LUMP_W-1:0] head_mem [HANDLE_COUNT];
    logic [LINK_W-1:0] link_mem [LUMP_COUNT];
    logic [FILL_W-1:0] fill_mem [LUMP_COUNT];

    logic [LUMP_W-1:0] r_head_q;
    logic [LINK_W-1:0] r_link_q;
    logic [FILL_W-1:0] r_fill_q;
    logic [LUMP_W-1:0] r_cur;
    logic [LUMP_W-1:0] r_head;

    logic                r_valid;
    logic [STAT_W-1:0]   r_status;
    logic [HANDLE_W-1:0] r_hout;
    logic [ADDR_W-1:0]   r_aout;

    logic [HANDLE_W-1:0] free_h;
    logic [LUMP_W-1:0]   free_l;
    logic [LUMP_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   base, diff, res_addr;
    logic                accept;

    assign i_cmd.ready = i_ctl.idle;
    assign accept      = i_cmd.valid && i_ctl.idle;

    // Lowest free handle and lowest free lump.
    always_comb begin
        free_h = '0;
        for (int i = HANDLE_COUNT - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                free_h = HANDLE_W'(i);
            end
        end
        free_l = '0;
        for (int i = LUMP_COUNT - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                free_l = LUMP_W'(i);
            end
        end
    end

    assign base = lump_addr(r_cur, '0);
    assign diff = r_where - base;

    always_comb begin
        o_sts           = '0;
        o_sts.accept    = accept;
        o_sts.cmd       = r_cmd;
        o_sts.hfree_any = !(&r_in_use);
        o_sts.lfree_any = !(&r_busy);
        o_sts.handle_ok = (32'(r_h) < HANDLE_COUNT) && r_in_use[r_h];
        o_sts.size_ok   = (r_bytes != '0) && (r_bytes <= USABLE);
        o_sts.need_lump = ((FILL_W + 1)'(LUMP_BYTES) - {1'b0, r_fill_q}) < {1'b0, r_bytes};
        o_sts.match     = (r_where > base) && (diff <= ADDR_W'(LUMP_BYTES)) &&
                          (diff >= ADDR_W'(HEADER_BYTES));
        o_sts.link_end  = (r_link_q >= NO_LINK);
        o_sts.out_free  = !r_valid || o_res.ready;
    end

    always_comb begin
        unique case (i_ctl.op)
            OP_LOAD_CUR:        rd_addr = r_head_q;
            OP_STEP, OP_SEARCH: rd_addr = r_link_q[LUMP_W-1:0];
            OP_MATCH:           rd_addr = r_head;
            default:            rd_addr = r_cur;
        endcase
        unique case (i_ctl.op)
            OP_ALLOC_NEW:     res_addr = lump_addr(free_l, HEADER_FILL);
            OP_BUMP, OP_MARK: res_addr = lump_addr(r_cur, r_fill_q);
            default:          res_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd.command;
            r_h     <= i_cmd.handle_in;
            r_bytes <= i_cmd.byte_count;
            r_where <= i_cmd.rollback_address;
        end
        r_head_q <= head_mem[r_h];
        r_link_q <= link_mem[rd_addr];
        r_fill_q <= fill_mem[rd_addr];
        unique case (i_ctl.op)
            OP_CREATE: begin
                head_mem[free_h] <= free_l;
                link_mem[free_l] <= NO_LINK;
                fill_mem[free_l] <= HEADER_FILL;
            end
            OP_ALLOC_NEW: begin
                head_mem[r_h]    <= free_l;
                link_mem[free_l] <= LINK_W'(r_cur);
                fill_mem[free_l] <= HEADER_FILL + r_bytes;
            end
            OP_BUMP: begin
                fill_mem[r_cur] <= r_fill_q + r_bytes;
            end
            OP_MATCH: begin
                head_mem[r_h]   <= r_cur;
                fill_mem[r_cur] <= diff[FILL_W-1:0];
            end
            default: begin
            end
        endcase
        unique case (i_ctl.op)
            OP_LOAD_CUR: begin
                r_cur  <= r_head_q;
                r_head <= r_head_q;
            end
            OP_STEP, OP_SEARCH: r_cur <= r_link_q[LUMP_W-1:0];
            OP_MATCH:           r_cur <= r_head;
            default: begin
            end
        endcase
        if (i_ctl.finish) begin
            r_status <= i_ctl.status;
            r_hout   <= (i_ctl.op == OP_CREATE) ? free_h : '0;
            r_aout   <= res_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_busy   <= '0;
            r_valid  <= 1'b0;
        end else begin
            unique case (i_ctl.op)
                OP_CREATE: begin
                    r_in_use[free_h] <= 1'b1;
                    r_busy[free_l]   <= 1'b1;
                end
                OP_ALLOC_NEW: r_busy[free_l] <= 1'b1;
                OP_STEP, OP_LAST: r_busy[r_cur] <= 1'b0;
                OP_LAST_FREE: begin
                    r_busy[r_cur] <= 1'b0;
                    r_in_use[r_h] <= 1'b0;
                end
                default: begin
                end
            endcase
            if (i_ctl.finish) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.status      = r_status;
    assign o_res.handle_out  = r_hout;
    assign o_res.address_out = r_aout;

endmodule
`default_nettype wire

@@ rtl/handle_region_bump_allocator.sv @@
// Top level of the handle region bump allocator: controller plus datapath.
// Depends on hrba_pkg, hrba_if, hrba_ctrl and hrba_dp.
//
//  Channel  Direction  Handshake    Word carried
//  i_cmd    in         valid/ready  command, handle_in, byte_count, rollback_address
//  o_res    out        valid/ready  status, handle_out, address_out
//
// One command word is worked on at a time. Create and a word rejected at decode
// finish in the decode state; alloc and mark pass the head read and finish in
// the lump state. Free releases the chain one lump per step; free-from searches
// the chain for the lump holding the rollback address, then releases each newer
// lump. Chain walks make one registered link-memory read per cycle.
// Reset is synchronous and active low; the busy bits clear at once, so no
// clearing pass is needed. A result waiting on o_res holds the controller
// only at the cycle that would load the next result.
`default_nettype none
module handle_region_bump_allocator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hrba_cmd_if.sink   i_cmd,
    hrba_res_if.source o_res
);
    import hrba_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // The controller decides the sequence from the datapath's status flags.
    hrba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // The datapath holds all storage and both channel registers.
    hrba_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_res   (o_res),
        .i_ctl   (ctl),
        .o_sts   (sts)
    );

endmodule
`default_nettype wire

@@ rtl/hrba_chk.sv @@
// Port checker for the allocator and its bind to the top level.
// Depends on hrba_pkg.
`default_nettype none
module hrba_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [hrba_pkg::STAT_W-1:0]   i_status,
    input wire logic [hrba_pkg::HANDLE_W-1:0] i_handle,
    input wire logic [hrba_pkg::ADDR_W-1:0]   i_address
);
    import hrba_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) &&
        $stable(i_address))
        else $error("result word dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second word taken while one is in work");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_handle == '0 && i_address == '0)
        else $error("failed result carries a handle or address");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid)
        else $error("result appeared in the cycle after acceptance");

endmodule

bind handle_region_bump_allocator hrba_chk u_hrba_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_handle    (o_res.handle_out),
    .i_address   (o_res.address_out)
);
`default_nettype wire
